// File: rtl/bitmap_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Concurrent checks that fall away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, codes and types of the allocator and its parts.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int NUM_PAGES_DEF = 4096;

    // The used map is held as words of this many pages.
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    localparam int OPCODE_W   = 1;
    localparam int PAGE_W     = 12;
    localparam int COUNT_W    = 13;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic {
        DIR_UP   = 1'b0,
        DIR_DOWN = 1'b1
    } t_dir;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_search_res;

endpackage

// File: rtl/bitmap_page_allocator.sv
// Request path: a request refused at once (no page left or a target past the last page) goes
// straight to the done state; any other passes the modify state, an allocate whose following
// page opens the next map word also the next-word check, and a map scan reads one 64-page map
// word a cycle. One request at a time: ready returns with the reply word's valid, and a reply
// not taken stalls the next request in the done state until it is. Reset: synchronous, active
// low; a clearing pass then writes MAP_WORDS map words while no word is accepted.
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Keeps a used bit per page in a word RAM, a used count and a next-free hint,
// and serves allocate and free requests under a small sequencer.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [11:0] target_page, [15:12] zero
    input  logic [bpa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic [bpa_pkg::OPCODE_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [11:0] granted_page, [24:12] used_count, [31:25] zero
    output logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] ok
    output logic                           m_axis_tuser
);

    localparam int WORD_W    = bpa_pkg::WORD_W;
    localparam int BIT_W     = bpa_pkg::BIT_W;
    localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int HINT_W    = ADDR_W + BIT_W;
    localparam int CNT_W     = $clog2(NUM_PAGES + 1);
    localparam int LEFT_W    = $clog2(MAP_WORDS + 1);
    localparam int LAST_BITS = NUM_PAGES - (MAP_WORDS - 1) * WORD_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);
    localparam logic [WORD_W-1:0] LAST_MASK = (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} :
                                              ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MODIFY = 6'b000100,
        S_NEXT   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [ADDR_W-1:0]           r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]            r_used_total, n_used_total;
    logic [HINT_W-1:0]           r_hint, n_hint;
    logic [HINT_W-1:0]           r_tgt, n_tgt;
    bpa_pkg::t_opcode            r_op, n_op;
    logic                        r_ok, n_ok;
    logic [HINT_W-1:0]           r_grant, n_grant;
    logic [ADDR_W-1:0]           r_scan_addr, n_scan_addr;
    logic [ADDR_W-1:0]           r_chk_addr, n_chk_addr;
    logic                        r_chk_vld, n_chk_vld;
    logic [LEFT_W-1:0]           r_left, n_left;
    bpa_pkg::t_dir               r_dir, n_dir;
    logic                        r_out_vld, n_out_vld;
    logic                        r_out_ok, n_out_ok;
    logic [bpa_pkg::PAGE_W-1:0]  r_out_grant, n_out_grant;
    logic [bpa_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [WORD_W-1:0]     w_wdata;
    logic                  w_re;
    logic [ADDR_W-1:0]     w_raddr;
    logic [WORD_W-1:0]     w_rdata;
    logic [WORD_W-1:0]     w_mask;
    bpa_pkg::t_search_res  w_res;

    logic                  w_accept;
    logic [31:0]           w_tgt_wide;
    logic [31:0]           w_grant_wide;
    logic [31:0]           w_count_wide;
    logic [BIT_W-1:0]      w_bit;
    logic [BIT_W-1:0]      w_bit_nxt;
    logic [WORD_W-1:0]     w_bit_mask;
    logic [WORD_W-1:0]     w_set_word;
    logic                  w_nxt_in_range;

    bpa_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Bits past the last page of the last word count as used.
    assign w_mask = (r_chk_addr == LAST_ADDR) ? LAST_MASK : {WORD_W{1'b1}};

    bpa_word_search u_search (
        .i_data (w_rdata),
        .i_mask (w_mask),
        .i_dir  (r_dir),
        .o_res  (w_res)
    );

    assign s_axis_tready  = (r_state == S_IDLE);
    assign w_accept       = s_axis_tvalid && s_axis_tready;
    assign w_tgt_wide     = 32'(s_axis_tdata[bpa_pkg::PAGE_W-1:0]);
    assign w_bit          = r_tgt[BIT_W-1:0];
    assign w_bit_nxt      = w_bit + BIT_W'(1);
    assign w_bit_mask     = WORD_W'(1) << w_bit;
    assign w_set_word     = w_rdata | w_bit_mask;
    assign w_nxt_in_range = (32'(r_tgt) + 32'd1) < 32'(NUM_PAGES);
    assign w_grant_wide   = 32'(r_grant);
    assign w_count_wide   = 32'(r_used_total);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_used_total = r_used_total;
        n_hint       = r_hint;
        n_tgt        = r_tgt;
        n_op         = r_op;
        n_ok         = r_ok;
        n_grant      = r_grant;
        n_scan_addr  = r_scan_addr;
        n_chk_addr   = r_chk_addr;
        n_chk_vld    = r_chk_vld;
        n_left       = r_left;
        n_dir        = r_dir;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_ok     = r_out_ok;
        n_out_grant  = r_out_grant;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_tgt[HINT_W-1:BIT_W];
        w_wdata      = w_set_word;
        w_re         = 1'b0;
        w_raddr      = r_tgt[HINT_W-1:BIT_W];

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = bpa_pkg::t_opcode'(s_axis_tuser);
                    n_ok    = 1'b0;
                    n_grant = '0;
                    if (s_axis_tuser == bpa_pkg::OP_ALLOC) begin
                        n_tgt = r_hint;
                        if (32'(r_used_total) < 32'(NUM_PAGES)) begin
                            w_re    = 1'b1;
                            w_raddr = r_hint[HINT_W-1:BIT_W];
                            n_state = S_MODIFY;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_tgt = w_tgt_wide[HINT_W-1:0];
                        if (w_tgt_wide < 32'(NUM_PAGES)) begin
                            w_re    = 1'b1;
                            w_raddr = w_tgt_wide[HINT_W-1:BIT_W];
                            n_state = S_MODIFY;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_MODIFY: begin
                n_scan_addr = '0;
                n_left      = LEFT_W'(MAP_WORDS);
                n_chk_vld   = 1'b0;
                if (r_op == bpa_pkg::OP_ALLOC) begin
                    w_we         = 1'b1;
                    w_wdata      = w_set_word;
                    n_used_total = r_used_total + CNT_W'(1);
                    n_ok         = 1'b1;
                    n_grant      = r_tgt;
                    n_dir        = bpa_pkg::DIR_UP;
                    if (!w_nxt_in_range) begin
                        n_state = S_SCAN;
                    end else if (w_bit != BIT_W'(WORD_W - 1)) begin
                        // The following page sits in the word just updated.
                        if (!w_set_word[w_bit_nxt]) begin
                            n_hint  = r_tgt + HINT_W'(1);
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_tgt[HINT_W-1:BIT_W] + ADDR_W'(1);
                        n_state = S_NEXT;
                    end
                end else begin
                    if (w_rdata[w_bit]) begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata & ~w_bit_mask;
                        if (r_used_total != '0) begin
                            n_used_total = r_used_total - CNT_W'(1);
                        end
                        n_ok        = 1'b1;
                        n_dir       = bpa_pkg::DIR_DOWN;
                        n_scan_addr = LAST_ADDR;
                        n_state     = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_NEXT: begin
                if (!w_rdata[0]) begin
                    n_hint  = r_tgt + HINT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_scan_addr = '0;
                    n_left      = LEFT_W'(MAP_WORDS);
                    n_chk_vld   = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued one word per cycle; each word is searched when it returns.
                if (r_left != '0) begin
                    w_re       = 1'b1;
                    w_raddr    = r_scan_addr;
                    n_chk_addr = r_scan_addr;
                    n_chk_vld  = 1'b1;
                    n_left     = r_left - LEFT_W'(1);
                    if (r_dir == bpa_pkg::DIR_UP) begin
                        n_scan_addr = r_scan_addr + ADDR_W'(1);
                    end else begin
                        n_scan_addr = r_scan_addr - ADDR_W'(1);
                    end
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld && w_res.found) begin
                    n_hint  = {r_chk_addr, w_res.pos};
                    n_state = S_DONE;
                end else if (r_chk_vld && (r_left == '0)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_grant = w_grant_wide[bpa_pkg::PAGE_W-1:0];
                    n_out_count = w_count_wide[bpa_pkg::COUNT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_used_total <= '0;
            r_hint       <= '0;
            r_chk_vld    <= 1'b0;
            r_left       <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_used_total <= n_used_total;
            r_hint       <= n_hint;
            r_chk_vld    <= n_chk_vld;
            r_left       <= n_left;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt       <= n_tgt;
        r_op        <= n_op;
        r_ok        <= n_ok;
        r_grant     <= n_grant;
        r_scan_addr <= n_scan_addr;
        r_chk_addr  <= n_chk_addr;
        r_dir       <= n_dir;
        r_out_ok    <= n_out_ok;
        r_out_grant <= n_out_grant;
        r_out_count <= n_out_count;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {{(bpa_pkg::OUT_DATA_W - bpa_pkg::COUNT_W - bpa_pkg::PAGE_W){1'b0}},
                            r_out_count, r_out_grant};

    `BPA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !s_axis_tready, "ready after accept")
    `BPA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_used_total) <= 32'(NUM_PAGES), "count over range")
    `BPA_ASSERT_IMP(a_refused_no_grant, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[bpa_pkg::PAGE_W-1:0] == '0, "refused word grants a page")
    `BPA_ASSERT_IMP(a_write_states, i_clk, i_rst_n, w_we, (r_state == S_CLEAR) || (r_state == S_MODIFY), "map written outside update")
    `BPA_ASSERT_IMP(a_scan_dir_free, i_clk, i_rst_n, (r_state == S_SCAN) && (r_op == bpa_pkg::OP_FREE), r_dir == bpa_pkg::DIR_DOWN, "free scan runs upwards")

endmodule

// File: rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpa_word_search.sv
// ----------------------------------------------------------------------------
// Free-page search over one map word
// Finds the lowest or the highest free page among the valid bits of a word.
// ----------------------------------------------------------------------------
module bpa_word_search (
    input  logic [bpa_pkg::WORD_W-1:0] i_data,
    input  logic [bpa_pkg::WORD_W-1:0] i_mask,
    input  bpa_pkg::t_dir              i_dir,
    output bpa_pkg::t_search_res       o_res
);

    logic [bpa_pkg::WORD_W-1:0] w_free;

    always_comb begin
        w_free    = ~i_data & i_mask;
        o_res     = '0;
        o_res.found = |w_free;
        if (i_dir == bpa_pkg::DIR_UP) begin
            for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
                if (w_free[i]) begin
                    o_res.pos = bpa_pkg::BIT_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < bpa_pkg::WORD_W; i++) begin
                if (w_free[i]) begin
                    o_res.pos = bpa_pkg::BIT_W'(i);
                end
            end
        end
    end

endmodule

// File: verif/bitmap_page_allocator_checker.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator checker
// Watches both stream channels, keeps its own copy of the used map, count and
// hint, works out the reply to every accepted request and compares each reply
// word with the oldest one outstanding.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_checker #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    // [11:0] target_page, [15:12] zero
    input  logic [bpa_pkg::IN_DATA_W-1:0]  i_in_data,
    // [0] opcode
    input  logic [bpa_pkg::OPCODE_W-1:0]   i_in_user,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    // [11:0] granted_page, [24:12] used_count, [31:25] zero
    input  logic [bpa_pkg::OUT_DATA_W-1:0] i_out_data,
    // [0] ok
    input  logic                           i_out_user,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        ok;
        logic [bpa_pkg::PAGE_W-1:0]  page;
        logic [bpa_pkg::COUNT_W-1:0] count;
    } t_reply;

    bit [NUM_PAGES-1:0] page_used;
    int unsigned        pages_in_use;
    int unsigned        hint_page;
    t_reply             pending_replies[$];
    int                 mismatches = 0;

    function automatic t_reply apply_page_request(bpa_pkg::t_opcode op,
                                                  logic [bpa_pkg::PAGE_W-1:0] page);
        t_reply      r;
        int unsigned grant;
        r = '0;
        if (op == bpa_pkg::OP_ALLOC) begin
            if (pages_in_use < NUM_PAGES) begin
                grant = hint_page;
                page_used[grant] = 1'b1;
                pages_in_use++;
                r.ok   = 1'b1;
                r.page = grant[bpa_pkg::PAGE_W-1:0];
                if (grant + 1 < NUM_PAGES && !page_used[grant + 1]) begin
                    hint_page = grant + 1;
                end else begin
                    // Lowest free page; with none left the hint stays put.
                    for (int i = 0; i < NUM_PAGES; i++) begin
                        if (!page_used[i]) begin
                            hint_page = i;
                            break;
                        end
                    end
                end
            end
        end else if (page < NUM_PAGES && page_used[page]) begin
            page_used[page] = 1'b0;
            if (pages_in_use > 0) pages_in_use--;
            r.ok = 1'b1;
            // A full scan that keeps the last free page, i.e. the highest one.
            for (int i = 0; i < NUM_PAGES; i++) begin
                if (!page_used[i]) hint_page = i;
            end
        end
        r.count = pages_in_use[bpa_pkg::COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            page_used    = '0;
            pages_in_use = 0;
            hint_page    = 0;
            pending_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                pending_replies.push_back(
                    apply_page_request(bpa_pkg::t_opcode'(i_in_user),
                                       i_in_data[bpa_pkg::PAGE_W-1:0]));
            end
            if (i_out_valid && i_out_ready) begin
                got.ok    = i_out_user;
                got.page  = i_out_data[bpa_pkg::PAGE_W-1:0];
                got.count = i_out_data[bpa_pkg::PAGE_W +: bpa_pkg::COUNT_W];
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply word with nothing outstanding: ",
                                 $realtime, "ok=%0b page=%0d count=%0d",
                                 got.ok, got.page, got.count);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.ok !== want.ok || got.page !== want.page ||
                        got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: reply mismatch: ", $realtime,
                                     "expected ok=%0b page=%0d count=%0d, ",
                                     want.ok, want.page, want.count,
                                     "got ok=%0b page=%0d count=%0d",
                                     got.ok, got.page, got.count);
                    end
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = pending_replies.size();
    end

endmodule

// File: verif/bitmap_page_allocator_tb.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free requests into the allocator, first a directed set
// on an empty map and then random mixes, with random gaps and stalls on both
// channels; the checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 100;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [bpa_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [bpa_pkg::OPCODE_W-1:0]   s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    int fail_count;
    int pending;
    bit tx_steady     = 1'b0;
    int hold_requests = 0;

    bitmap_page_allocator #(
        .NUM_PAGES(NUM_PAGES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    bitmap_page_allocator_checker #(
        .NUM_PAGES(NUM_PAGES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else if (r < 98) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    task automatic send_word(bpa_pkg::t_opcode op, logic [bpa_pkg::PAGE_W-1:0] page);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bpa_pkg::IN_DATA_W-bpa_pkg::PAGE_W){1'b0}}, page};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, steady stretches, and one long hold on request.
    initial begin
        int stall_left;
        int cycle_no;
        int holds_served;
        bit rx_steady;
        stall_left    = 0;
        cycle_no      = 0;
        holds_served  = 0;
        rx_steady     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle_no++;
            if (cycle_no % 256 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_steady) stall_left = gap_len();
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int                         alloc_pct;
        int                         mode;
        bpa_pkg::t_opcode           op;
        logic [bpa_pkg::PAGE_W-1:0] page;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bpa_pkg::OP_ALLOC;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map: frees of free pages, the extremes, and the hint moving
        // to the highest free page after a free.
        send_word(bpa_pkg::OP_FREE,  12'd0);
        send_word(bpa_pkg::OP_FREE,  12'hFFF);
        send_word(bpa_pkg::OP_ALLOC, 12'hFFF);
        send_word(bpa_pkg::OP_ALLOC, 12'h000);
        send_word(bpa_pkg::OP_ALLOC, 12'h5A5);
        send_word(bpa_pkg::OP_FREE,  12'd1);
        send_word(bpa_pkg::OP_FREE,  12'd1);
        send_word(bpa_pkg::OP_ALLOC, 12'hA5A);
        send_word(bpa_pkg::OP_ALLOC, 12'd0);
        send_word(bpa_pkg::OP_FREE,  12'hFFF);
        send_word(bpa_pkg::OP_FREE,  12'd0);
        send_word(bpa_pkg::OP_FREE,  12'd2);
        send_word(bpa_pkg::OP_FREE,  12'd1);
        wait_drained();

        // Random mixes: the allocate share sets whether the map drains or
        // refills, and the target window decides how often frees hit. One
        // segment runs against a long receiver hold so that the block backs up.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(0, 2))
                0:       alloc_pct = 15;
                1:       alloc_pct = 50;
                default: alloc_pct = 85;
            endcase
            mode      = $urandom_range(0, 3);
            tx_steady = ($urandom_range(0, 3) == 0);
            if (seg == 5) hold_requests++;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < alloc_pct) ? bpa_pkg::OP_ALLOC
                                                         : bpa_pkg::OP_FREE;
                case (mode)
                    0:       page = bpa_pkg::PAGE_W'($urandom);
                    1:       page = bpa_pkg::PAGE_W'($urandom_range(0, 15));
                    2:       page = bpa_pkg::PAGE_W'($urandom_range(NUM_PAGES - 16,
                                                                    NUM_PAGES - 1));
                    default: page = $urandom_range(0, 1) ? bpa_pkg::PAGE_W'($urandom)
                                  : ($urandom_range(0, 1) ? 12'h000 : 12'hFFF);
                endcase
                send_word(op, page);
            end
            if ($urandom_range(0, 2) == 0) wait_drained();
        end
        tx_steady = 1'b0;

        wait_drained();
        repeat (80) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_word_search.sv
rtl/bitmap_page_allocator.sv
verif/bitmap_page_allocator_checker.sv
verif/bitmap_page_allocator_tb.sv
